// ----- hw/rtl/hmb_pkg.sv -----
// Shared types and constants for the horizontal motion blur block.
package hmb_pkg;

  localparam int MAX_BLUR = 16;
  localparam int PIX_W    = 8;
  localparam int LEN_W    = 5;
  localparam int COL_W    = 12;
  localparam int CNT_W    = $clog2(MAX_BLUR + 1);
  localparam int PTR_W    = (MAX_BLUR > 1) ? $clog2(MAX_BLUR) : 1;
  localparam int SUM_W    = $clog2(MAX_BLUR * 255 + 1);

  // floor(x / n) == (x * ceil(2^S / n)) >> S for all x < 2^SUM_W, n <= MAX_BLUR
  localparam int RECIP_SHIFT = SUM_W + CNT_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [0:0] REG_BLUR_SPAN   = 1'b0;
  localparam logic [0:0] REG_IMAGE_WIDTH = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t pixel;
    logic   row_end;
  } cmd_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_blue;
    logic [CNT_W-1:0] count;
    logic             last;
  } job_t;

  typedef enum logic {
    BK_RUN,
    BK_FLUSH
  } back_state_t;

endpackage

// ----- hw/rtl/hmb_front.sv -----
// Input side: accepts pixels, tracks the column and tags row ends.
module hmb_front
  import hmb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [COL_W-1:0] image_width,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] red_in,
  input  logic [PIX_W-1:0] green_in,
  input  logic [PIX_W-1:0] blue_in,
  output logic             push_valid,
  input  logic             push_ready,
  output cmd_t             push_cmd
);

  logic [COL_W-1:0] column;
  logic [COL_W-1:0] last_column;
  logic             accept;

  // zero width behaves as width one
  assign last_column = (image_width == '0) ? '0 : image_width - COL_W'(1);

  assign in_stall              = !push_ready;
  assign push_valid            = in_valid;
  assign accept                = in_valid && push_ready;
  assign push_cmd.pixel.red    = red_in;
  assign push_cmd.pixel.green  = green_in;
  assign push_cmd.pixel.blue   = blue_in;
  assign push_cmd.row_end      = (column >= last_column);

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
    end else if (accept) begin
      column <= push_cmd.row_end ? '0 : column + COL_W'(1);
    end
  end

endmodule

// ----- hw/rtl/hmb_cmd_fifo.sv -----
// Short command queue between the input side and the window engine.
module hmb_cmd_fifo
  import hmb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  cmd_t                entries [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr;
  logic [FQ_PTR_W-1:0] rd_ptr;
  logic [FQ_CNT_W-1:0] fill;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (fill != FQ_CNT_W'(FQ_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FQ_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + FQ_CNT_W'(1);
        2'b01:   fill <= fill - FQ_CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- hw/rtl/hmb_window.sv -----
// Window engine: keeps pending pixels and channel sums, issues averaging jobs.
module hmb_window
  import hmb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] blur_span,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  output logic             job_valid,
  input  logic             job_ready,
  output job_t             job
);

  back_state_t      state, state_next;
  pixel_t           win [MAX_BLUR];
  logic [PTR_W-1:0] head, head_next, head_adv, tail;
  logic [CNT_W-1:0] count, count_next, count_inc, len;
  logic [CNT_W:0]   tail_sum;
  logic [SUM_W-1:0] sum_red, sum_green, sum_blue;
  logic [SUM_W-1:0] sum_red_next, sum_green_next, sum_blue_next;
  logic [SUM_W-1:0] add_red, add_green, add_blue;
  pixel_t           head_pix;
  logic             win_we;

  // clamp blur length to 1..MAX_BLUR
  always_comb begin
    if (blur_span == '0) begin
      len = CNT_W'(1);
    end else if (int'(blur_span) > MAX_BLUR) begin
      len = CNT_W'(MAX_BLUR);
    end else begin
      len = CNT_W'(blur_span);
    end
  end

  always_comb begin
    tail_sum = (CNT_W+1)'(head) + (CNT_W+1)'(count);
    if (tail_sum >= (CNT_W+1)'(MAX_BLUR)) begin
      tail_sum = tail_sum - (CNT_W+1)'(MAX_BLUR);
    end
  end

  assign tail      = tail_sum[PTR_W-1:0];
  assign head_adv  = (head == PTR_W'(MAX_BLUR - 1)) ? '0 : head + PTR_W'(1);
  assign count_inc = count + CNT_W'(1);
  // empty window: the oldest pixel is the one arriving now
  assign head_pix  = (count == '0) ? cmd.pixel : win[head];
  assign add_red   = sum_red   + SUM_W'(cmd.pixel.red);
  assign add_green = sum_green + SUM_W'(cmd.pixel.green);
  assign add_blue  = sum_blue  + SUM_W'(cmd.pixel.blue);

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    sum_red_next   = sum_red;
    sum_green_next = sum_green;
    sum_blue_next  = sum_blue;
    cmd_pop        = 1'b0;
    win_we         = 1'b0;
    job_valid      = 1'b0;
    job            = '0;
    case (state)
      BK_RUN: begin
        if (cmd_valid && job_ready) begin
          cmd_pop = 1'b1;
          win_we  = 1'b1;
          if (cmd.row_end) begin
            sum_red_next   = add_red;
            sum_green_next = add_green;
            sum_blue_next  = add_blue;
            count_next     = count_inc;
            state_next     = BK_FLUSH;
          end else if (count_inc >= len) begin
            // window complete: average it and drop the oldest pixel
            job_valid      = 1'b1;
            job.sum_red    = add_red;
            job.sum_green  = add_green;
            job.sum_blue   = add_blue;
            job.count      = count_inc;
            job.last       = 1'b1;
            sum_red_next   = add_red   - SUM_W'(head_pix.red);
            sum_green_next = add_green - SUM_W'(head_pix.green);
            sum_blue_next  = add_blue  - SUM_W'(head_pix.blue);
            head_next      = head_adv;
          end else begin
            sum_red_next   = add_red;
            sum_green_next = add_green;
            sum_blue_next  = add_blue;
            count_next     = count_inc;
          end
        end
      end
      BK_FLUSH: begin
        job_valid     = 1'b1;
        job.sum_red   = sum_red;
        job.sum_green = sum_green;
        job.sum_blue  = sum_blue;
        job.count     = count;
        job.last      = (count == CNT_W'(1));
        if (job_ready) begin
          sum_red_next   = sum_red   - SUM_W'(head_pix.red);
          sum_green_next = sum_green - SUM_W'(head_pix.green);
          sum_blue_next  = sum_blue  - SUM_W'(head_pix.blue);
          count_next     = count - CNT_W'(1);
          head_next      = head_adv;
          if (count == CNT_W'(1)) begin
            state_next = BK_RUN;
          end
        end
      end
      default: begin
        state_next = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_RUN;
      head      <= '0;
      count     <= '0;
      sum_red   <= '0;
      sum_green <= '0;
      sum_blue  <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      sum_red   <= sum_red_next;
      sum_green <= sum_green_next;
      sum_blue  <= sum_blue_next;
    end
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win[tail] <= cmd.pixel;
    end
  end

  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == BK_FLUSH |-> count != '0)
    else $error("flush with empty window");

  a_empty_sums_zero: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> (sum_red == '0 && sum_green == '0 && sum_blue == '0))
    else $error("empty window with nonzero sums");

  a_flush_drains: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FLUSH && job_ready && count == CNT_W'(1))
      |=> (state == BK_RUN && count == '0))
    else $error("flush did not leave an empty window");

  a_pop_gated: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (job_ready && state == BK_RUN))
    else $error("command taken while averaging path is blocked");

endmodule

// ----- hw/rtl/hmb_avg_pipe.sv -----
// Averaging pipeline: reciprocal multiply, then output register.
module hmb_avg_pipe
  import hmb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  job_t             job,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] red_out,
  output logic [PIX_W-1:0] green_out,
  output logic [PIX_W-1:0] blue_out,
  output logic             last_of_run
);

  logic [RECIP_W-1:0] recip_tab [2**CNT_W];
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod_red, prod_green, prod_blue;
  logic               s1_valid, s1_last, s1_take, s2_take;

  for (genvar gi = 0; gi < 2**CNT_W; gi++) begin : g_recip
    if (gi == 0) begin : g_zero
      assign recip_tab[gi] = '0;
    end else begin : g_val
      localparam logic [RECIP_W-1:0] RECIP_VAL =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(gi) - 64'd1) / 64'(gi));
      assign recip_tab[gi] = RECIP_VAL;
    end
  end

  assign recip     = recip_tab[job.count];
  assign s2_take   = !out_valid || !out_stall;
  assign s1_take   = !s1_valid || s2_take;
  assign job_ready = s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid <= job_valid;
      end
      if (s2_take) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && job_valid) begin
      prod_red   <= PROD_W'(job.sum_red)   * PROD_W'(recip);
      prod_green <= PROD_W'(job.sum_green) * PROD_W'(recip);
      prod_blue  <= PROD_W'(job.sum_blue)  * PROD_W'(recip);
      s1_last    <= job.last;
    end
    if (s2_take && s1_valid) begin
      red_out     <= prod_red[RECIP_SHIFT +: PIX_W];
      green_out   <= prod_green[RECIP_SHIFT +: PIX_W];
      blue_out    <= prod_blue[RECIP_SHIFT +: PIX_W];
      last_of_run <= s1_last;
    end
  end

endmodule

// ----- hw/rtl/horizontal_motion_blur_core.sv -----
// Top level of the horizontal motion blur block: config registers and datapath.
//
// Usage:
//   Pixels enter in raster order on the in channel (in_valid / in_stall,
//   red_in, green_in, blue_in). Each result on the out channel is the
//   per-channel truncated average of one source pixel and the pixels to its
//   right in the same row, blur_span pixels in all, fewer at the row end.
//   last_of_run marks the final result caused by one input pixel.
//   blur_span (address 0) and image_width (address 4) are written over the
//   APB port while the block is idle; zero counts as one and blur_span
//   saturates at MAX_BLUR.
// Flow and throughput:
//   A result passes the command queue, the product register and the output
//   register. The window engine takes one pixel per cycle while the averaging
//   pipeline accepts jobs; the last pixel of a row instead starts a drain that
//   issues one job per pending pixel, up to blur_span, before new pixels are
//   taken. A 4-entry command queue keeps accepting pixels meanwhile.
// Reset:
//   Synchronous rst empties the queue, window, sums and pipeline and sets
//   both registers to 1.
// Stall:
//   While out_stall is high the output register holds, the pipeline backs
//   up, and once the queue fills in_stall rises.
module horizontal_motion_blur_core
  import hmb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // pixel input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  red_in,
  input  logic [PIX_W-1:0]  green_in,
  input  logic [PIX_W-1:0]  blue_in,
  // result output
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  red_out,
  output logic [PIX_W-1:0]  green_out,
  output logic [PIX_W-1:0]  blue_out,
  output logic              last_of_run
);

  logic [LEN_W-1:0] blur_span;
  logic [COL_W-1:0] image_width;
  logic [0:0]       reg_index;

  // front to queue
  logic push_valid, push_ready;
  cmd_t push_cmd;
  // queue to window engine
  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  // window engine to averaging pipeline
  logic job_valid, job_ready;
  job_t job;

  // registers sit on 4-byte boundaries; select by the word bit
  assign reg_index = paddr[ADDR_W-1 -: 1];
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blur_span   <= LEN_W'(1);
      image_width <= COL_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        REG_BLUR_SPAN:   blur_span   <= pwdata[LEN_W-1:0];
        REG_IMAGE_WIDTH: image_width <= pwdata[COL_W-1:0];
        default: begin
          blur_span <= blur_span;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_BLUR_SPAN:   prdata = DATA_W'(blur_span);
      REG_IMAGE_WIDTH: prdata = DATA_W'(image_width);
      default:         prdata = '0;
    endcase
  end

  // accept pixels and tag the last one of each row
  hmb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .image_width (image_width),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  // decouple input transfers from row-end drains
  hmb_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (cmd_valid),
    .pop        (cmd_pop),
    .pop_cmd    (cmd)
  );

  // hold the window and running sums, issue one job per result
  hmb_window u_window (
    .clk         (clk),
    .rst         (rst),
    .blur_span   (blur_span),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job)
  );

  // divide the sums by the pixel count and register the result
  hmb_avg_pipe u_avg_pipe (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .last_of_run (last_of_run)
  );

endmodule
